// ===== hw/rtl/csr_adj_pkg.sv =====
// shared types, sizes and codes for the compressed-row adjacency transpose
// used by csr_adj_ctrl, csr_adj_datapath and csr_adjacency_transpose_core
package csr_adj_pkg;

   localparam int MAX_TARGETS = 16;
   localparam int MAX_ENTRIES = 32;

   localparam int TGT_W  = $clog2(MAX_TARGETS);       // target row index
   localparam int TC_W   = $clog2(MAX_TARGETS + 1);   // target_count register
   localparam int ADDR_W = $clog2(MAX_ENTRIES);       // entry store address
   localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);   // entry counts and offsets

   localparam logic [TC_W-1:0]  TC_RESET = TC_W'(MAX_TARGETS);
   localparam logic [CNT_W-1:0] ENT_FULL = CNT_W'(MAX_ENTRIES);

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_RANGE = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;

   typedef struct packed {
      logic [7:0] source_row;
      logic [7:0] target;
      logic       has_entry;
      logic       last;
   } req_type;

   typedef struct packed {
      logic [3:0]       target_row;
      logic [7:0]       source_out;
      logic [CNT_W-1:0] row_offset;
      logic             entry_valid;
      logic [CNT_W-1:0] total_entries;
      logic [1:0]       status;
      logic             last_out;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic accept;
      logic emit_error;
      logic pre_step;
      logic scat;
      logic emit_marker;
      logic row_open;
      logic emit_entry;
      logic finish;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic err_next_nz;
      logic t_last;
      logic cnt_zero;
      logic rem_one;
      logic scat_idle;
   } stat_type;

endpackage

// ===== hw/rtl/csr_adjacency_transpose_core.sv =====
// top level of the compressed-row adjacency transpose: controller plus datapath
// depends on csr_adj_pkg, csr_adj_ctrl and csr_adj_datapath
// loading: one request per cycle while busy is low; an error on a last request gives its
//   single result in the next cycle and busy stays low
// after a clean last: a prefix pass over the target rows, a scatter pass over the loaded
//   entries, then the results, with a row-open step per non-empty target row; results never stall
// reset (synchronous) clears the sequencer, counts and error, target_count returns to 16
module csr_adjacency_transpose_core (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  csr_adj_pkg::req_type         req_item,
   input  logic                        csr_wr_en,
   input  logic [csr_adj_pkg::TC_W-1:0] csr_wr_data,
   output logic                        rsp_strobe,
   output csr_adj_pkg::rsp_type         rsp_item
);

   csr_adj_pkg::cmd_type  cmd;
   csr_adj_pkg::stat_type stat;

   csr_adj_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_last (req_item.last),
      .stat     (stat),
      .cmd      (cmd),
      .busy     (busy)
   );

   csr_adj_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_item    (req_item),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cmd         (cmd),
      .stat        (stat),
      .rsp_strobe  (rsp_strobe),
      .rsp_item    (rsp_item)
   );

endmodule

// ===== hw/rtl/csr_adj_ctrl.sv =====
// sequencer for load, prefix, scatter and emit phases
// depends on csr_adj_pkg for the command and status structs
module csr_adj_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic                 req_last,
   input  csr_adj_pkg::stat_type stat,
   output csr_adj_pkg::cmd_type  cmd,
   output logic                 busy
);

   localparam logic [2:0] S_IDLE    = 3'd0;
   localparam logic [2:0] S_PREFIX  = 3'd1;
   localparam logic [2:0] S_SCATTER = 3'd2;
   localparam logic [2:0] S_ROW     = 3'd3;
   localparam logic [2:0] S_ENTRY   = 3'd4;

   logic [2:0] state_ff, state_in;

   assign busy = (state_ff != S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.accept = 1'b1;
               if (req_last) begin
                  if (stat.err_next_nz) begin
                     cmd.emit_error = 1'b1;
                  end else begin
                     state_in = S_PREFIX;
                  end
               end
            end
         end
         S_PREFIX: begin
            cmd.pre_step = 1'b1;
            if (stat.t_last) begin
               state_in = S_SCATTER;
            end
         end
         S_SCATTER: begin
            cmd.scat = 1'b1;
            if (stat.scat_idle) begin
               state_in = S_ROW;
            end
         end
         S_ROW: begin
            if (stat.cnt_zero) begin
               cmd.emit_marker = 1'b1;
               if (stat.t_last) begin
                  cmd.finish = 1'b1;
                  state_in   = S_IDLE;
               end
            end else begin
               cmd.row_open = 1'b1;
               state_in     = S_ENTRY;
            end
         end
         S_ENTRY: begin
            cmd.emit_entry = 1'b1;
            if (stat.rem_one) begin
               if (stat.t_last) begin
                  cmd.finish = 1'b1;
                  state_in   = S_IDLE;
               end else begin
                  state_in = S_ROW;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== hw/rtl/csr_adj_datapath.sv =====
// entry stores, per-target counts, offsets and the result register
// depends on csr_adj_pkg; driven by commands from csr_adj_ctrl
module csr_adj_datapath (
   input  logic                       clock,
   input  logic                       reset,
   input  csr_adj_pkg::req_type        req_item,
   input  logic                       csr_wr_en,
   input  logic [csr_adj_pkg::TC_W-1:0] csr_wr_data,
   input  csr_adj_pkg::cmd_type        cmd,
   output csr_adj_pkg::stat_type       stat,
   output logic                       rsp_strobe,
   output csr_adj_pkg::rsp_type        rsp_item
);

   localparam int TGT_W  = csr_adj_pkg::TGT_W;
   localparam int TC_W   = csr_adj_pkg::TC_W;
   localparam int ADDR_W = csr_adj_pkg::ADDR_W;
   localparam int CNT_W  = csr_adj_pkg::CNT_W;
   localparam int NT     = csr_adj_pkg::MAX_TARGETS;
   localparam int NE     = csr_adj_pkg::MAX_ENTRIES;

   logic [TC_W-1:0]  tc_ff;
   logic [CNT_W-1:0] loaded_ff;
   logic [1:0]       err_ff;
   logic [CNT_W-1:0] counts_ff [NT];
   logic [CNT_W-1:0] next_pos_ff [NT];

   logic [7:0]       ent_src_mem [NE];
   logic [TGT_W-1:0] ent_tgt_mem [NE];
   logic [7:0]       trans_mem [NE];
   logic [7:0]       ent_src_q;
   logic [TGT_W-1:0] ent_tgt_q;
   logic [7:0]       trans_q;

   logic [TGT_W-1:0] t_ff;
   logic [CNT_W-1:0] acc_ff;
   logic [CNT_W-1:0] i_ff;
   logic             rd_v_ff;
   logic [CNT_W-1:0] p_ff, p_in;
   logic [CNT_W-1:0] beg_ff;
   logic [CNT_W-1:0] rem_ff;
   csr_adj_pkg::rsp_type rsp_ff;
   logic             rsp_valid_ff;

   logic [TGT_W-1:0] req_tgt;
   logic [TGT_W-1:0] cnt_addr;
   logic [CNT_W-1:0] cnt_sel;
   logic             in_range;
   logic             load_ok;
   logic [1:0]       err_next;
   logic             t_last;
   logic             issue;
   logic [CNT_W-1:0] pos;
   logic             tgt_ok;
   logic             run_clear;

   assign req_tgt  = req_item.target[TGT_W-1:0];
   assign cnt_addr = cmd.accept ? req_tgt : t_ff;
   assign cnt_sel  = counts_ff[cnt_addr];
   assign in_range = (req_item.target < 8'(tc_ff));
   assign load_ok  = cmd.accept && req_item.has_entry && in_range
                     && (loaded_ff < csr_adj_pkg::ENT_FULL);
   assign t_last   = ({1'b0, t_ff} == (tc_ff - TC_W'(1)));
   assign issue    = cmd.scat && (i_ff < loaded_ff);
   assign pos      = next_pos_ff[ent_tgt_q];
   // entries whose target is not below the current target_count are skipped
   assign tgt_ok   = ({1'b0, ent_tgt_q} < tc_ff);
   assign run_clear = cmd.finish || cmd.emit_error;

   // first error of the run is kept
   always_comb begin
      err_next = err_ff;
      if (err_ff == csr_adj_pkg::ST_OK && req_item.has_entry) begin
         if (!in_range) begin
            err_next = csr_adj_pkg::ST_RANGE;
         end else if (loaded_ff >= csr_adj_pkg::ENT_FULL) begin
            err_next = csr_adj_pkg::ST_FULL;
         end
      end
   end

   always_comb begin
      p_in = p_ff;
      if (cmd.accept) begin
         p_in = '0;
      end else if (cmd.emit_entry) begin
         p_in = p_ff + CNT_W'(1);
      end
   end

   assign stat.err_next_nz = (err_next != csr_adj_pkg::ST_OK);
   assign stat.t_last      = t_last;
   assign stat.cnt_zero    = (cnt_sel == '0);
   assign stat.rem_one     = (rem_ff == CNT_W'(1));
   assign stat.scat_idle   = (i_ff == loaded_ff) && !rd_v_ff;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         tc_ff        <= csr_adj_pkg::TC_RESET;
         loaded_ff    <= '0;
         err_ff       <= csr_adj_pkg::ST_OK;
         rd_v_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < NT; k++) begin
            counts_ff[k] <= '0;
         end
      end else begin
         if (csr_wr_en) begin
            if (csr_wr_data == '0) begin
               tc_ff <= TC_W'(1);
            end else if (csr_wr_data > csr_adj_pkg::TC_RESET) begin
               tc_ff <= csr_adj_pkg::TC_RESET;
            end else begin
               tc_ff <= csr_wr_data;
            end
         end
         rd_v_ff      <= issue;
         rsp_valid_ff <= cmd.emit_error || cmd.emit_marker || cmd.emit_entry;
         if (run_clear) begin
            loaded_ff <= '0;
            err_ff    <= csr_adj_pkg::ST_OK;
            for (int k = 0; k < NT; k++) begin
               counts_ff[k] <= '0;
            end
         end else if (cmd.accept) begin
            err_ff <= err_next;
            if (load_ok) begin
               loaded_ff          <= loaded_ff + CNT_W'(1);
               counts_ff[req_tgt] <= cnt_sel + CNT_W'(1);
            end
         end
      end
   end

   // walk counters
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         t_ff   <= '0;
         acc_ff <= '0;
         i_ff   <= '0;
      end else begin
         if (cmd.pre_step) begin
            acc_ff <= acc_ff + cnt_sel;
            t_ff   <= t_last ? '0 : t_ff + TGT_W'(1);
         end else if (cmd.emit_marker || (cmd.emit_entry && stat.rem_one)) begin
            t_ff <= t_ff + TGT_W'(1);
         end
         if (issue) begin
            i_ff <= i_ff + CNT_W'(1);
         end
      end
      p_ff <= p_in;
      if (cmd.row_open) begin
         beg_ff <= p_ff;
         rem_ff <= cnt_sel;
      end else if (cmd.emit_entry) begin
         rem_ff <= rem_ff - CNT_W'(1);
      end
   end

   // next free slot per target: start offsets, then bumped by the scatter
   always_ff @(posedge clock) begin
      if (cmd.pre_step) begin
         next_pos_ff[t_ff] <= acc_ff;
      end else if (rd_v_ff && tgt_ok) begin
         next_pos_ff[ent_tgt_q] <= pos + CNT_W'(1);
      end
   end

   // entry stores in arrival order
   always_ff @(posedge clock) begin
      if (load_ok) begin
         ent_src_mem[loaded_ff[ADDR_W-1:0]] <= req_item.source_row;
         ent_tgt_mem[loaded_ff[ADDR_W-1:0]] <= req_tgt;
      end
      ent_src_q <= ent_src_mem[i_ff[ADDR_W-1:0]];
      ent_tgt_q <= ent_tgt_mem[i_ff[ADDR_W-1:0]];
   end

   // transposed list, read one ahead of the emit pointer
   always_ff @(posedge clock) begin
      if (rd_v_ff && tgt_ok) begin
         trans_mem[pos[ADDR_W-1:0]] <= ent_src_q;
      end
      trans_q <= trans_mem[p_in[ADDR_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_error) begin
         rsp_ff.target_row    <= '0;
         rsp_ff.source_out    <= '0;
         rsp_ff.row_offset    <= '0;
         rsp_ff.entry_valid   <= 1'b0;
         rsp_ff.total_entries <= '0;
         rsp_ff.status        <= err_next;
         rsp_ff.last_out      <= 1'b1;
      end else if (cmd.emit_marker) begin
         rsp_ff.target_row    <= 4'(t_ff);
         rsp_ff.source_out    <= '0;
         rsp_ff.row_offset    <= p_ff;
         rsp_ff.entry_valid   <= 1'b0;
         rsp_ff.total_entries <= loaded_ff;
         rsp_ff.status        <= csr_adj_pkg::ST_OK;
         rsp_ff.last_out      <= t_last;
      end else if (cmd.emit_entry) begin
         rsp_ff.target_row    <= 4'(t_ff);
         rsp_ff.source_out    <= trans_q;
         rsp_ff.row_offset    <= beg_ff;
         rsp_ff.entry_valid   <= 1'b1;
         rsp_ff.total_entries <= loaded_ff;
         rsp_ff.status        <= csr_adj_pkg::ST_OK;
         rsp_ff.last_out      <= t_last && stat.rem_one;
      end
   end

   assign rsp_strobe = rsp_valid_ff;
   assign rsp_item   = rsp_ff;

endmodule
